// ----- rtl/irg_pkg.sv -----
// shared types and constants for the isaac random generator
`default_nettype none

package irg_pkg;

  localparam int LOG_TABLE_SIZE_DEF = 8;
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  localparam logic [1:0] MODE_SEED = 2'd0;
  localparam logic [1:0] MODE_INIT = 2'd1;
  localparam logic [1:0] MODE_NEXT = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SEED,
    OP_EXP0,
    OP_EXP1,
    OP_CLR,
    OP_SCR,
    OP_LD,
    OP_WR,
    OP_GS,
    OP_G0,
    OP_G1,
    OP_G2,
    OP_G3,
    OP_G4,
    OP_G5,
    OP_NXT,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] sub;
    logic [3:0] k;
    logic       src;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic wl_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/irg_dp.sv -----
// datapath: mix memory, result store, mixing registers and output register
`default_nettype none

module irg_dp
  import irg_pkg::*;
#(
  parameter int LOG_TABLE_SIZE = LOG_TABLE_SIZE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire cmd_t                      cmd,
  input  wire logic [LOG_TABLE_SIZE-1:0] i_idx,
  input  wire logic [31:0]               seed,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [31:0]                    out_tdata,
  output stat_t                          stat
);

  localparam int AW    = LOG_TABLE_SIZE;
  localparam int TSIZE = 1 << AW;
  localparam logic [AW-1:0] HALF = AW'(TSIZE / 2);

  logic [31:0]     mm_mem [TSIZE];
  logic [TSIZE-1:0] mm_vld_r;
  logic [31:0]     mm_q_r;
  logic            mm_qv_r;
  logic [31:0]     rs_mem [TSIZE];
  logic [31:0]     rs_q_r;

  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [31:0] a_r, b_r, bc_r, x_r, p_r, y_r;
  logic [31:0] a_nxt, b_nxt, bc_nxt, x_nxt, p_nxt, y_nxt;
  logic [AW:0] wl_r, wl_nxt;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [AW-1:0] ld_addr, mm_raddr, mm_waddr, rs_raddr;
  logic [31:0]   mm_wdata, rs_wdata, rd_mm, ld_data, sel, shv, t0, y_sum;
  logic          mm_we, rs_we, rs_re, out_free;
  logic [AW:0]   wl_dec;

  assign ld_addr  = i_idx + AW'(cmd.k[2:0]);
  assign rd_mm    = mm_qv_r ? mm_q_r : 32'd0;
  assign ld_data  = cmd.src ? rd_mm : rs_q_r;
  assign out_free = !out_valid_r || out_tready;
  assign wl_dec   = wl_r - 1'b1;
  assign y_sum    = rd_mm + a_r + b_r;

  always_comb begin
    unique case (cmd.op)
      OP_G0:   mm_raddr = i_idx;
      OP_G1:   mm_raddr = i_idx + HALF;
      OP_G2:   mm_raddr = AW'(x_r >> 2);
      OP_G4:   mm_raddr = AW'(y_r >> (AW + 2));
      default: mm_raddr = ld_addr;
    endcase
  end

  assign mm_we    = (cmd.op == OP_G3) || (cmd.op == OP_WR);
  assign mm_waddr = (cmd.op == OP_G3) ? i_idx : ld_addr;
  assign mm_wdata = (cmd.op == OP_G3) ? y_sum : v_r[cmd.k[2:0]];

  assign rs_we    = (cmd.op == OP_EXP0) || (cmd.op == OP_G5);
  assign rs_wdata = (cmd.op == OP_EXP0) ? x_r : rd_mm + x_r;
  assign rs_re    = (cmd.op == OP_NXT) || (cmd.op == OP_LD);
  assign rs_raddr = (cmd.op == OP_NXT) ? wl_dec[AW-1:0] : ld_addr;

  always_ff @(posedge clk) begin
    if (mm_we) begin
      mm_mem[mm_waddr] <= mm_wdata;
    end
    mm_q_r  <= mm_mem[mm_raddr];
    mm_qv_r <= mm_vld_r[mm_raddr];
    if (rs_we) begin
      rs_mem[i_idx] <= rs_wdata;
    end
    if (rs_re) begin
      rs_q_r <= rs_mem[rs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mm_vld_r <= '0;
    end else if (mm_we) begin
      mm_vld_r[mm_waddr] <= 1'b1;
    end
  end

  // one sub-step of the init scramble, then rotate by one word; sel is the batch accumulator shift
  always_comb begin
    unique case (cmd.sub)
      3'd0:    shv = v_r[1] << 11;
      3'd1:    shv = v_r[1] >> 2;
      3'd2:    shv = v_r[1] << 8;
      3'd3:    shv = v_r[1] >> 16;
      3'd4:    shv = v_r[1] << 10;
      3'd5:    shv = v_r[1] >> 4;
      3'd6:    shv = v_r[1] << 8;
      default: shv = v_r[1] >> 9;
    endcase
    t0 = v_r[0] ^ shv;
    unique case (i_idx[1:0])
      2'd0:    sel = a_r << 13;
      2'd1:    sel = a_r >> 6;
      2'd2:    sel = a_r << 2;
      default: sel = a_r >> 16;
    endcase
  end

  always_comb begin
    v_nxt        = v_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    bc_nxt       = bc_r;
    x_nxt        = x_r;
    p_nxt        = p_r;
    y_nxt        = y_r;
    wl_nxt       = wl_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (cmd.op)
      OP_SEED: x_nxt = seed;
      OP_EXP0: p_nxt = x_r + 32'd1;
      OP_EXP1: x_nxt = 32'(p_r * x_r);
      OP_CLR: begin
        for (int n = 0; n < 8; n++) v_nxt[n] = GOLDEN;
        a_nxt  = '0;
        b_nxt  = '0;
        bc_nxt = '0;
      end
      OP_SCR: begin
        v_nxt[0] = v_r[1] + v_r[2];
        v_nxt[1] = v_r[2];
        v_nxt[2] = v_r[3] + t0;
        v_nxt[3] = v_r[4];
        v_nxt[4] = v_r[5];
        v_nxt[5] = v_r[6];
        v_nxt[6] = v_r[7];
        v_nxt[7] = t0;
      end
      OP_LD: begin
        if (cmd.k != 4'd0) begin
          v_nxt[3'(cmd.k - 4'd1)] = v_r[3'(cmd.k - 4'd1)] + ld_data;
        end
      end
      OP_GS: begin
        bc_nxt = bc_r + 32'd1;
        b_nxt  = b_r + bc_r + 32'd1;
      end
      OP_G1: x_nxt = rd_mm;
      OP_G2: a_nxt = (a_r ^ sel) + rd_mm;
      OP_G3: y_nxt = y_sum;
      OP_G5: begin
        b_nxt = rd_mm + x_r;
        if (cmd.last) begin
          wl_nxt = (AW+1)'(TSIZE);
        end
      end
      OP_NXT: wl_nxt = wl_dec;
      OP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rs_q_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r         <= '0;
      b_r         <= '0;
      bc_r        <= '0;
      wl_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      bc_r        <= bc_nxt;
      wl_r        <= wl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    x_r        <= x_nxt;
    p_r        <= p_nxt;
    y_r        <= y_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign stat.wl_zero  = (wl_r == '0);
  assign stat.out_free = out_free;

endmodule

`default_nettype wire

// ----- rtl/irg_ctrl.sv -----
// controller: sequencing of seeding, initialisation, batch generation and reads
`default_nettype none

module irg_ctrl
  import irg_pkg::*;
#(
  parameter int LOG_TABLE_SIZE = LOG_TABLE_SIZE_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  input  wire logic [1:0]                in_mode,
  input  wire stat_t                     stat,
  output cmd_t                           cmd,
  output logic [LOG_TABLE_SIZE-1:0]      i_idx
);

  localparam int AW = LOG_TABLE_SIZE;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_EXP0 = 16'h0002,
    S_EXP1 = 16'h0004,
    S_CLR  = 16'h0008,
    S_SCR  = 16'h0010,
    S_LD   = 16'h0020,
    S_WR   = 16'h0040,
    S_GS   = 16'h0080,
    S_G0   = 16'h0100,
    S_G1   = 16'h0200,
    S_G2   = 16'h0400,
    S_G3   = 16'h0800,
    S_G4   = 16'h1000,
    S_G5   = 16'h2000,
    S_NXT  = 16'h4000,
    S_OUT  = 16'h8000
  } state_t;

  state_t      state_r, state_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [2:0]  j_r, j_nxt;
  logic [1:0]  sc_r, sc_nxt;
  logic [3:0]  k_r, k_nxt;
  logic        seed_r, seed_nxt, pass_r, pass_nxt, pre_r, pre_nxt, gfn_r, gfn_nxt;
  logic        accept, last_i, blk_last;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign last_i    = (i_r == '1);
  assign blk_last  = ((i_r | AW'(7)) == '1);
  assign i_idx     = i_r;

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    sc_nxt    = sc_r;
    k_nxt     = k_r;
    seed_nxt  = seed_r;
    pass_nxt  = pass_r;
    pre_nxt   = pre_r;
    gfn_nxt   = gfn_r;
    cmd.op    = OP_NONE;
    cmd.sub   = j_r;
    cmd.k     = k_r;
    cmd.src   = pass_r;
    cmd.last  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_SEED: begin
              cmd.op    = OP_SEED;
              seed_nxt  = 1'b1;
              i_nxt     = '0;
              state_nxt = S_EXP0;
            end
            MODE_INIT: begin
              seed_nxt  = 1'b0;
              state_nxt = S_CLR;
            end
            MODE_NEXT: begin
              if (stat.wl_zero) begin
                gfn_nxt   = 1'b1;
                state_nxt = S_GS;
              end else begin
                state_nxt = S_NXT;
              end
            end
            default: ;
          endcase
        end
      end
      S_EXP0: begin
        cmd.op    = OP_EXP0;
        state_nxt = S_EXP1;
      end
      S_EXP1: begin
        cmd.op = OP_EXP1;
        i_nxt  = i_r + 1'b1;
        state_nxt = last_i ? S_CLR : S_EXP0;
      end
      S_CLR: begin
        cmd.op    = OP_CLR;
        pre_nxt   = 1'b1;
        sc_nxt    = '0;
        j_nxt     = '0;
        state_nxt = S_SCR;
      end
      S_SCR: begin
        cmd.op = OP_SCR;
        j_nxt  = j_r + 1'b1;
        if (j_r == 3'd7) begin
          k_nxt = '0;
          if (pre_r) begin
            sc_nxt = sc_r + 1'b1;
            if (sc_r == 2'd3) begin
              pre_nxt   = 1'b0;
              i_nxt     = '0;
              pass_nxt  = 1'b0;
              state_nxt = seed_r ? S_LD : S_SCR;
            end
          end else begin
            state_nxt = S_WR;
          end
        end
      end
      S_LD: begin
        cmd.op = OP_LD;
        k_nxt  = k_r + 1'b1;
        if (k_r == 4'd8) begin
          j_nxt     = '0;
          state_nxt = S_SCR;
        end
      end
      S_WR: begin
        cmd.op = OP_WR;
        k_nxt  = k_r + 1'b1;
        if (k_r == 4'd7) begin
          k_nxt = '0;
          i_nxt = i_r + AW'(8);
          if (blk_last) begin
            i_nxt = '0;
            if (seed_r && !pass_r) begin
              pass_nxt  = 1'b1;
              state_nxt = S_LD;
            end else begin
              gfn_nxt   = 1'b0;
              state_nxt = S_GS;
            end
          end else begin
            state_nxt = seed_r ? S_LD : S_SCR;
          end
        end
      end
      S_GS: begin
        cmd.op    = OP_GS;
        i_nxt     = '0;
        state_nxt = S_G0;
      end
      S_G0: begin
        cmd.op    = OP_G0;
        state_nxt = S_G1;
      end
      S_G1: begin
        cmd.op    = OP_G1;
        state_nxt = S_G2;
      end
      S_G2: begin
        cmd.op    = OP_G2;
        state_nxt = S_G3;
      end
      S_G3: begin
        cmd.op    = OP_G3;
        state_nxt = S_G4;
      end
      S_G4: begin
        cmd.op    = OP_G4;
        state_nxt = S_G5;
      end
      S_G5: begin
        cmd.op   = OP_G5;
        cmd.last = last_i;
        i_nxt    = i_r + 1'b1;
        if (last_i) begin
          state_nxt = gfn_r ? S_NXT : S_IDLE;
        end else begin
          state_nxt = S_G0;
        end
      end
      S_NXT: begin
        cmd.op    = OP_NXT;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      sc_r    <= '0;
      k_r     <= '0;
      seed_r  <= 1'b0;
      pass_r  <= 1'b0;
      pre_r   <= 1'b0;
      gfn_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      sc_r    <= sc_nxt;
      k_r     <= k_nxt;
      seed_r  <= seed_nxt;
      pass_r  <= pass_nxt;
      pre_r   <= pre_nxt;
      gfn_r   <= gfn_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/isaac_random_generator_core.sv -----
// top level of the isaac 32-bit random generator
//
// usage: one input beat per request on in_*; mode 0 seeds from the given
// word, mode 1 initialises without a seed, mode 2 asks for the next word,
// mode 3 is taken and ignored. only mode 2 gives an output beat on out_*.
// in_tready is high only while the controller is idle; one request is worked
// on at a time, and all mix memory reads run on its single read port.
// next word with words left: the result store is read in S_NXT, then S_OUT
// loads the output register once it is free; new requests wait for idle.
// next word with the batch used up: a batch refill (S_GS, then S_G0 to S_G5
// per entry, reads on the single read port) runs before S_NXT and S_OUT.
// unseeded init: clear, pre-scramble, per block scramble and write, refill.
// seed: expansion, then init that loads each block first, and one refill.
// reset clears the mix memory (valid bits), the accumulators and the word
// count; the first next-word request then builds a batch from zero state.
// a stalled receiver holds the output register; the next request can still
// be accepted and runs until its own result would need the register.
`default_nettype none

module isaac_random_generator_core
  import irg_pkg::*;
#(
  parameter int LOG_TABLE_SIZE = LOG_TABLE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // mode [1:0], seed_value [33:2]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // random_word [31:0]
);

  cmd_t                      cmd;
  stat_t                     stat;
  logic [LOG_TABLE_SIZE-1:0] i_idx;

  irg_ctrl #(
    .LOG_TABLE_SIZE(LOG_TABLE_SIZE)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_mode  (in_tdata[1:0]),
    .stat     (stat),
    .cmd      (cmd),
    .i_idx    (i_idx)
  );

  irg_dp #(
    .LOG_TABLE_SIZE(LOG_TABLE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .i_idx     (i_idx),
    .seed      (in_tdata[33:2]),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .stat      (stat)
  );

`ifndef ASSERT_OFF
  a_next_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == MODE_NEXT |=> !in_tready)
    else $error("next-word request did not occupy the controller");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == MODE_SEED |=> !in_tready ##1 !in_tready)
    else $error("seed request finished too early");

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == MODE_INIT |=> !$rose(out_tvalid))
    else $error("init request produced an output beat");
`endif

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// self-checking testbench for the isaac random generator core
`timescale 1ns / 100ps

module testbench;
  import irg_pkg::*;

  localparam int TBL = 256;
  localparam int TMASK = TBL - 1;
  localparam longint CYCLE_LIMIT = 20000000;

  class word_scoreboard;
    logic [31:0] mix_mem[TBL];
    logic [31:0] rsl[TBL];
    logic [31:0] acc_a, prev_b, batch_cnt;
    int unsigned words_left;
    logic [31:0] want_q[$];
    int mismatches;
    int words_checked;

    function void clear_state();
      int i;
      for (i = 0; i < TBL; i++) begin
        mix_mem[i] = '0;
        rsl[i] = '0;
      end
      acc_a = '0;
      prev_b = '0;
      batch_cnt = '0;
      words_left = 0;
    endfunction

    function void mix8(ref logic [31:0] v[8]);
      v[0] ^= v[1] << 11; v[3] += v[0]; v[1] += v[2];
      v[1] ^= v[2] >> 2;  v[4] += v[1]; v[2] += v[3];
      v[2] ^= v[3] << 8;  v[5] += v[2]; v[3] += v[4];
      v[3] ^= v[4] >> 16; v[6] += v[3]; v[4] += v[5];
      v[4] ^= v[5] << 10; v[7] += v[4]; v[5] += v[6];
      v[5] ^= v[6] >> 4;  v[0] += v[5]; v[6] += v[7];
      v[6] ^= v[7] << 8;  v[1] += v[6]; v[7] += v[0];
      v[7] ^= v[0] >> 9;  v[2] += v[7]; v[0] += v[1];
    endfunction

    function void refill_batch();
      logic [31:0] a, b, x, y, s;
      int i;
      a = acc_a;
      batch_cnt += 1;
      b = prev_b + batch_cnt;
      for (i = 0; i < TBL; i++) begin
        x = mix_mem[i];
        case (i & 3)
          0: s = a << 13;
          1: s = a >> 6;
          2: s = a << 2;
          default: s = a >> 16;
        endcase
        a = (a ^ s) + mix_mem[(i + TBL / 2) & TMASK];
        y = mix_mem[(x >> 2) & TMASK] + a + b;
        mix_mem[i] = y;
        b = mix_mem[(y >> 10) & TMASK] + x;
        rsl[i] = b;
      end
      prev_b = b;
      acc_a = a;
    endfunction

    function void golden_init(bit seeded);
      logic [31:0] v[8];
      int i, k;
      acc_a = '0;
      prev_b = '0;
      batch_cnt = '0;
      for (k = 0; k < 8; k++) v[k] = GOLDEN;
      for (k = 0; k < 4; k++) mix8(v);
      for (i = 0; i < TBL; i += 8) begin
        if (seeded) for (k = 0; k < 8; k++) v[k] += rsl[i + k];
        mix8(v);
        for (k = 0; k < 8; k++) mix_mem[i + k] = v[k];
      end
      if (seeded) begin
        for (i = 0; i < TBL; i += 8) begin
          for (k = 0; k < 8; k++) v[k] += mix_mem[i + k];
          mix8(v);
          for (k = 0; k < 8; k++) mix_mem[i + k] = v[k];
        end
      end
      refill_batch();
      words_left = TBL;
    endfunction

    function void note_request(logic [1:0] mode, logic [31:0] seed);
      int i;
      if (mode == MODE_SEED) begin
        rsl[0] = seed;
        for (i = 1; i < TBL; i++) rsl[i] = (rsl[i - 1] + 32'd1) * rsl[i - 1];
        golden_init(1'b1);
      end else if (mode == MODE_INIT) begin
        golden_init(1'b0);
      end else if (mode == MODE_NEXT) begin
        if (words_left == 0) begin
          refill_batch();
          words_left = TBL - 1;
        end else begin
          words_left -= 1;
        end
        want_q.push_back(rsl[words_left & TMASK]);
      end
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] w;
      words_checked++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      w = want_q.pop_front();
      if (got !== w) begin
        mismatches++;
        if (mismatches <= 10) $display("word mismatch: expected %h got %h", w, got);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [39:0] in_tdata;
  logic [31:0] out_tdata;

  word_scoreboard sb;
  longint cycles;
  bit stim_done;
  int hold_off;
  int sent;

  isaac_random_generator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    sb = new();
    sb.clear_state();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cycles = 0;
    stim_done = 0;
    hold_off = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** isaac_random_generator_core: FAILED **");
      $finish;
    end
  end

  // output side: random stalls plus one long hold-off
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_word(out_tdata);
    end
  end

  task automatic send_beat(logic [1:0] mode, logic [31:0] seed, bit allow_gap);
    int gap;
    gap = (allow_gap && $urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, seed, mode};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(mode, seed);
    sent++;
  endtask

  function automatic logic [31:0] rand_seed();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hffffffff;
      2: return 32'h1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int i, r, n;
    logic [1:0] m;
    sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: next from reset state, mode three, seed extremes, init
    send_beat(MODE_NEXT, 32'h0, 0);
    send_beat(MODE_NEXT, 32'hffffffff, 0);
    send_beat(2'd3, 32'h12345678, 0);
    send_beat(MODE_NEXT, 32'h0, 0);
    send_beat(MODE_SEED, 32'h0, 0);
    send_beat(MODE_NEXT, 32'h0, 0);
    send_beat(MODE_SEED, 32'hffffffff, 0);
    send_beat(MODE_NEXT, 32'h0, 0);
    send_beat(MODE_NEXT, 32'h0, 0);
    send_beat(MODE_INIT, 32'hffffffff, 0);
    send_beat(MODE_NEXT, 32'h0, 0);
    send_beat(MODE_SEED, 32'haaaaaaaa, 0);
    send_beat(MODE_SEED, 32'h55555555, 0);
    send_beat(MODE_NEXT, 32'h0, 0);
    // long receiver stall while requests keep coming
    hold_off = 400;
    for (i = 0; i < 20; i++) send_beat(MODE_NEXT, $urandom(), 0);
    // random: mostly next-word runs, some past a batch boundary
    while (sent < 1700) begin
      r = $urandom_range(0, 19);
      if (r == 0) m = MODE_SEED;
      else if (r == 1) m = MODE_INIT;
      else if (r == 2) m = 2'd3;
      else m = MODE_NEXT;
      n = (m == MODE_NEXT) ? $urandom_range(1, 40) : 1;
      if (m == MODE_NEXT && $urandom_range(0, 9) == 0) n = 300;
      for (i = 0; i < n && sent < 1700; i++)
        send_beat(m, rand_seed(), $urandom_range(0, 3) != 0);
    end
    in_tvalid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    $display("sent %0d requests, checked %0d words across seeds, inits and refills",
             sent, sb.words_checked);
    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("** isaac_random_generator_core: PASSED **");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("** isaac_random_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
